FILE: rtl/core/bis_pkg.sv
// Package for the bilinear image scaler: sizes, codes, shared types and the
// frame address function. No dependencies.
package bis_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int XW         = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(STORE_DEPTH);

  localparam int COORD_W = 16;
  localparam int DIM_W   = 9;
  localparam int SCALE_W = 16;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int PROD_W  = COORD_W + SCALE_W;
  localparam int FRAC_W  = 8;
  localparam int WT_W    = 2 * FRAC_W + 1;   // 1-D weights are 0..256, product 0..65536
  localparam int ACC_W   = CHAN_W + WT_W;    // sum of p * w plus rounding bias
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_INVERSE_SCALE = 2'd2
  } cfg_reg_e;

  // Clamped neighbour indices and fractional weights of one request
  typedef struct packed {
    logic [XW-1:0]     x0;
    logic [XW-1:0]     x1;
    logic [YW-1:0]     y0;
    logic [YW-1:0]     y1;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } coord_t;

  typedef struct packed {
    logic start;  // register the scaled coordinates
    logic step;   // register the clamped indices
  } coord_ctl_t;

  typedef struct packed {
    logic clr;    // zero the channel accumulators
    logic acc;    // add pixel times weight
  } blend_ctl_t;

  function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    logic [AW-1:0] row_base;
    row_base = AW'(y) * AW'(MAX_WIDTH);
    return row_base + AW'(x);
  endfunction

endpackage

FILE: rtl/core/bis_if.sv
// Channel interfaces of the scaler: pixel item in, pixel result out and the
// register write channel. Depends on bis_pkg.
interface bis_in_if;
  import bis_pkg::*;
  logic                valid;
  logic                ready;
  opcode_e             opcode;
  logic [COORD_W-1:0]  coord_x;
  logic [COORD_W-1:0]  coord_y;
  logic [CHAN_W-1:0]   red_in;
  logic [CHAN_W-1:0]   green_in;
  logic [CHAN_W-1:0]   blue_in;

  modport source (output valid, opcode, coord_x, coord_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, red_in, green_in, blue_in,
                  output ready);
endinterface

interface bis_out_if;
  import bis_pkg::*;
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   red_out;
  logic [CHAN_W-1:0]   green_out;
  logic [CHAN_W-1:0]   blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface bis_cfg_if;
  import bis_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/bis_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/bis_coord.sv
// Coordinate mapper: scales the output coordinate by the inverse scale, then
// clamps the neighbour indices to the frame. Two register stages. Uses bis_pkg.
module bis_coord (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bis_pkg::coord_ctl_t          ctl_i,
  input  logic [bis_pkg::COORD_W-1:0]  coord_x_i,
  input  logic [bis_pkg::COORD_W-1:0]  coord_y_i,
  input  logic [bis_pkg::SCALE_W-1:0]  inv_scale_i,
  input  logic [bis_pkg::DIM_W-1:0]    width_i,
  input  logic [bis_pkg::DIM_W-1:0]    height_i,
  output bis_pkg::coord_t              coord_o
);
  import bis_pkg::*;

  logic [PROD_W-1:0] gx_q, gy_q;
  coord_t            coord_q, coord_d;

  logic [31:0] w_eff, h_eff, last_x, last_y;
  logic [PROD_W-FRAC_W-1:0] x0, y0;

  always_comb begin
    // zero acts as one, anything above the store size as the store size
    w_eff = 32'(width_i);
    if (width_i == '0) w_eff = 32'd1;
    else if (32'(width_i) > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    h_eff = 32'(height_i);
    if (height_i == '0) h_eff = 32'd1;
    else if (32'(height_i) > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
    last_x = w_eff - 32'd1;
    last_y = h_eff - 32'd1;

    x0 = gx_q[PROD_W-1:FRAC_W];
    y0 = gy_q[PROD_W-1:FRAC_W];

    coord_d.fx = gx_q[FRAC_W-1:0];
    coord_d.fy = gy_q[FRAC_W-1:0];
    if (32'(x0) >= last_x) begin
      coord_d.x0 = last_x[XW-1:0];
      coord_d.x1 = last_x[XW-1:0];
    end else begin
      coord_d.x0 = x0[XW-1:0];
      coord_d.x1 = x0[XW-1:0] + XW'(1);
    end
    if (32'(y0) >= last_y) begin
      coord_d.y0 = last_y[YW-1:0];
      coord_d.y1 = last_y[YW-1:0];
    end else begin
      coord_d.y0 = y0[YW-1:0];
      coord_d.y1 = y0[YW-1:0] + YW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q    <= '0;
      gy_q    <= '0;
      coord_q <= '0;
    end else begin
      if (ctl_i.start) begin
        gx_q <= PROD_W'(coord_x_i) * PROD_W'(inv_scale_i);
        gy_q <= PROD_W'(coord_y_i) * PROD_W'(inv_scale_i);
      end
      if (ctl_i.step) begin
        coord_q <= coord_d;
      end
    end
  end

  assign coord_o = coord_q;

endmodule

FILE: rtl/core/bis_blend.sv
// Blend unit: three channel lanes that accumulate pixel times 2-D weight over
// the four neighbours, then round half up and saturate. Uses bis_pkg.
module bis_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bis_pkg::blend_ctl_t         ctl_i,
  input  logic [bis_pkg::PIX_W-1:0]   pixel_i,
  input  logic [bis_pkg::WT_W-1:0]    weight_i,
  output logic [bis_pkg::PIX_W-1:0]   rgb_o
);
  import bis_pkg::*;

  logic [ACC_W-1:0] acc_q [3];
  logic [ACC_W-1:0] acc_d [3];

  always_comb begin
    logic [ACC_W-1:0] rounded;
    logic [ACC_W-FRAC_W*2-1:0] r;
    for (int k = 0; k < 3; k++) begin
      acc_d[k] = acc_q[k];
      if (ctl_i.clr) begin
        acc_d[k] = '0;
      end else if (ctl_i.acc) begin
        acc_d[k] = acc_q[k] + ACC_W'(pixel_i[CHAN_W*k +: CHAN_W]) * ACC_W'(weight_i);
      end
    end
    rgb_o = '0;
    for (int k = 0; k < 3; k++) begin
      rounded = acc_q[k] + ACC_W'(32'd1 << (2 * FRAC_W - 1));
      r       = rounded[ACC_W-1:2*FRAC_W];
      rgb_o[CHAN_W*k +: CHAN_W] = (r > (ACC_W-FRAC_W*2)'(255)) ? 8'hFF : r[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) acc_q[k] <= '0;
    end else begin
      for (int k = 0; k < 3; k++) acc_q[k] <= acc_d[k];
    end
  end

endmodule

FILE: rtl/core/bilinear_image_scaler_unit.sv
// Bilinear image scaler top level: register file, request sequencer, frame RAM.
// Depends on bis_pkg, bis_if, bis_ram, bis_coord and bis_blend.
// A load is written at acceptance; a request goes through multiply, clamp, four
// neighbour reads through the one frame RAM read port and the last accumulate.
// Input is accepted only while idle, so no new request is taken until the last
// result is registered, which waits while the output is stalled. Reset clears
// control state and the registers; frame contents stay undefined.
module bilinear_image_scaler_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  bis_in_if.sink    in_i,
  bis_out_if.source out_o,
  bis_cfg_if.sink   cfg_i
);
  import bis_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_READ,
    ST_LAST,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [1:0]         idx_q, idx_d;
  logic               rdv_q, rdv_d;
  logic [WT_W-1:0]    rd_w_q, rd_w_d;
  logic               out_valid_q, out_valid_d;
  logic [PIX_W-1:0]   out_rgb_q, out_rgb_d;
  logic [DIM_W-1:0]   width_q, height_q;
  logic [SCALE_W-1:0] inv_q;

  logic          in_acc, cfg_acc, load_ok;
  coord_ctl_t    coord_ctl;
  coord_t        coord;
  blend_ctl_t    blend_ctl;
  logic [PIX_W-1:0] rdata, rgb;
  logic [AW-1:0] raddr, waddr;
  logic [XW-1:0] rx;
  logic [YW-1:0] ry;
  logic [FRAC_W:0] wx, wy;
  logic [2*FRAC_W+1:0] wprod;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc  = in_i.valid && in_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  assign load_ok = (32'(in_i.coord_x) < 32'(MAX_WIDTH)) && (32'(in_i.coord_y) < 32'(MAX_HEIGHT));
  assign waddr   = pix_addr(in_i.coord_x[XW-1:0], in_i.coord_y[YW-1:0]);

  // neighbour order: bit 0 picks the right column, bit 1 the lower row
  assign rx    = idx_q[0] ? coord.x1 : coord.x0;
  assign ry    = idx_q[1] ? coord.y1 : coord.y0;
  assign raddr = pix_addr(rx, ry);
  assign wx    = idx_q[0] ? {1'b0, coord.fx} : (FRAC_W+1)'(256) - {1'b0, coord.fx};
  assign wy    = idx_q[1] ? {1'b0, coord.fy} : (FRAC_W+1)'(256) - {1'b0, coord.fy};
  assign wprod = wx * wy;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    rdv_d       = 1'b0;
    rd_w_d      = rd_w_q;
    out_valid_d = out_valid_q;
    out_rgb_d   = out_rgb_q;
    coord_ctl   = '0;
    blend_ctl   = '0;

    if (out_o.valid && out_o.ready) out_valid_d = 1'b0;
    blend_ctl.acc = rdv_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.opcode == OP_REQUEST) begin
          coord_ctl.start = 1'b1;
          state_d         = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        coord_ctl.step = 1'b1;
        blend_ctl.clr  = 1'b1;
        idx_d          = '0;
        state_d        = ST_READ;
      end
      ST_READ: begin
        rdv_d  = 1'b1;
        rd_w_d = wprod[WT_W-1:0];
        idx_d  = idx_q + 2'd1;
        if (idx_q == 2'd3) state_d = ST_LAST;
      end
      ST_LAST: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_rgb_d   = rgb;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rdv_q       <= 1'b0;
      rd_w_q      <= '0;
      out_valid_q <= 1'b0;
      out_rgb_q   <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rdv_q       <= rdv_d;
      rd_w_q      <= rd_w_d;
      out_valid_q <= out_valid_d;
      out_rgb_q   <= out_rgb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      inv_q    <= SCALE_W'(256);
    end else if (cfg_acc) begin
      case (cfg_i.index)
        REG_SOURCE_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
        REG_SOURCE_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
        REG_INVERSE_SCALE: inv_q    <= cfg_i.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.red_out   = out_rgb_q[2*CHAN_W +: CHAN_W];
  assign out_o.green_out = out_rgb_q[CHAN_W +: CHAN_W];
  assign out_o.blue_out  = out_rgb_q[0 +: CHAN_W];

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (in_acc && in_i.opcode == OP_LOAD && load_ok),
    .waddr_i (waddr),
    .wdata_i ({in_i.red_in, in_i.green_in, in_i.blue_in}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bis_coord u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (coord_ctl),
    .coord_x_i   (in_i.coord_x),
    .coord_y_i   (in_i.coord_y),
    .inv_scale_i (inv_q),
    .width_i     (width_q),
    .height_i    (height_q),
    .coord_o     (coord)
  );

  bis_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (blend_ctl),
    .pixel_i  (rdata),
    .weight_i (rd_w_q),
    .rgb_o    (rgb)
  );

endmodule
